// ----- sv/swmc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swmc_pkg
// Shared constants, types and helpers for the sliding-window median cost block.
// ----------------------------------------------------------------------------
package swmc_pkg;

  localparam int MAX_WINDOW  = 64;
  localparam int SAMPLE_BITS = 32;
  localparam int CFG_BITS    = 7;
  localparam int PTR_BITS    = $clog2(MAX_WINDOW);
  localparam int LEN_BITS    = $clog2(MAX_WINDOW + 1);
  localparam int COST_BITS   = SAMPLE_BITS + $clog2(MAX_WINDOW);
  localparam int CMP_BITS    = CFG_BITS + LEN_BITS;

  localparam logic [CFG_BITS-1:0] WINDOW_LEN_RESET = CFG_BITS'(3);

  // Control broadcast to every cell of the sort chain.
  typedef struct packed {
    logic                          clear;
    logic                          insert;
    logic                          shift;
    logic signed [SAMPLE_BITS-1:0] data;
  } cell_ctrl_t;

  // What one cell shows to its neighbors.
  typedef struct packed {
    logic                          valid;
    logic                          gt;
    logic signed [SAMPLE_BITS-1:0] value;
  } cell_link_t;

  // Effective window length: zero reads as one, large values saturate.
  function automatic logic [LEN_BITS-1:0] eff_len_f(input logic [CFG_BITS-1:0] wl);
    logic [CMP_BITS-1:0] wl_ext;
    logic [CMP_BITS-1:0] max_ext;
    wl_ext  = CMP_BITS'(wl);
    max_ext = CMP_BITS'(MAX_WINDOW);
    if (wl_ext == '0) begin
      return LEN_BITS'(1);
    end else if (wl_ext > max_ext) begin
      return LEN_BITS'(MAX_WINDOW);
    end else begin
      return LEN_BITS'(wl_ext);
    end
  endfunction

endpackage

// ----- sv/swmc_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swmc_cell
// One slot of the sorted chain: insert by broadcast compare, shift toward head.
// ----------------------------------------------------------------------------
module swmc_cell import swmc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cell_ctrl_t ctrl,
  input  cell_link_t prev,
  input  cell_link_t next,
  output cell_link_t link
);

  logic                          valid;
  logic signed [SAMPLE_BITS-1:0] value;
  logic                          gt;

  // Empty slots count as larger than anything.
  always_comb begin
    gt = !valid || (value > ctrl.data);
  end

  assign link = '{valid: valid, gt: gt, value: value};

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.clear) begin
      valid <= 1'b0;
    end else if (ctrl.insert) begin
      if (prev.gt) begin
        valid <= prev.valid;
      end else if (gt) begin
        valid <= 1'b1;
      end
    end else if (ctrl.shift) begin
      valid <= next.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.insert) begin
      if (prev.gt) begin
        value <= prev.value;
      end else if (gt) begin
        value <= ctrl.data;
      end
    end else if (ctrl.shift) begin
      value <= next.value;
    end
  end

endmodule

// ----- sv/swmc_chain.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swmc_chain
// Row of sort cells; ascending from the head, drained through the head.
// ----------------------------------------------------------------------------
module swmc_chain import swmc_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  input  cell_ctrl_t                    ctrl,
  output logic signed [SAMPLE_BITS-1:0] head
);

  localparam cell_link_t HEAD_LINK = '{valid: 1'b1, gt: 1'b0, value: '0};
  localparam cell_link_t TAIL_LINK = '{valid: 1'b0, gt: 1'b1, value: '0};

  cell_link_t link [MAX_WINDOW];

  for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
    cell_link_t prev_l;
    cell_link_t next_l;

    if (i == 0) begin : g_head
      assign prev_l = HEAD_LINK;
    end else begin : g_mid_p
      assign prev_l = link[i-1];
    end

    if (i == MAX_WINDOW - 1) begin : g_tail
      assign next_l = TAIL_LINK;
    end else begin : g_mid_n
      assign next_l = link[i+1];
    end

    swmc_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .ctrl (ctrl),
      .prev (prev_l),
      .next (next_l),
      .link (link[i])
    );
  end

  assign head = link[0].value;

endmodule

// ----- sv/sliding_window_median_cost.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_median_cost
// Median and sum of absolute deviations over the last L samples of a stream.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake              Payload
//   -------   --------------------   -------------------------------
//   in        in_valid / in_stall    sample (s32), restart
//   out       out_valid / out_stall  cost (u38), median (s32)
//   cfg       cfg_valid / cfg_ready  cfg_data = window_len (u7)
//
// Sequence: an item that leaves the window short of L samples is taken without
// stalling the input. A full-window item stalls the input while its last L
// samples are read from the ring memory (one port, registered read) into the
// sort chain and the last insert lands, then the chain drains through the
// accumulator, and then the result is handed to the output register.
// Reset: synchronous; empties the window, window_len returns to 3.
// Stalls: a finished result sits in the output register while the next
// request is taken; a held result only delays the hand-off step.
// ----------------------------------------------------------------------------
module sliding_window_median_cost import swmc_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  // input requests
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic                          restart,
  // results
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic        [COST_BITS-1:0]   cost,
  output logic signed [SAMPLE_BITS-1:0] median,
  // configuration
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic        [CFG_BITS-1:0]    cfg_data
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_GATHER = 4'b0010,
    ST_DRAIN  = 4'b0100,
    ST_DONE   = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  logic [CFG_BITS-1:0] window_len;
  logic [LEN_BITS-1:0] eff_len;
  logic [LEN_BITS-1:0] lower_n;
  logic [LEN_BITS-1:0] mid_idx;
  logic                odd_len;

  logic [LEN_BITS-1:0] fill_count;
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] wr_addr;
  logic [LEN_BITS-1:0] fill_new;
  logic                in_take;
  logic                full;

  // arrival ring
  logic signed [SAMPLE_BITS-1:0] ring [MAX_WINDOW];
  logic signed [SAMPLE_BITS-1:0] rd_data;
  logic        [PTR_BITS-1:0]    rd_ptr;
  logic        [LEN_BITS-1:0]    rd_cnt;
  logic                          rd_en;
  logic                          ins_valid;

  // drain / accumulate
  logic        [LEN_BITS-1:0]    drn_cnt;
  logic signed [COST_BITS-1:0]   acc;
  logic signed [COST_BITS-1:0]   head_ext;
  logic signed [SAMPLE_BITS-1:0] med;
  logic signed [SAMPLE_BITS-1:0] head;
  logic                          out_free;

  cell_ctrl_t ctrl;

  function automatic logic [PTR_BITS-1:0] ptr_inc(input logic [PTR_BITS-1:0] p);
    return (p == PTR_BITS'(MAX_WINDOW - 1)) ? '0 : p + PTR_BITS'(1);
  endfunction

  function automatic logic [PTR_BITS-1:0] ptr_dec(input logic [PTR_BITS-1:0] p);
    return (p == '0) ? PTR_BITS'(MAX_WINDOW - 1) : p - PTR_BITS'(1);
  endfunction

  // --------------------------------------------------------------------------
  // Configuration: always ready; the user must write it only between requests, as the block does not enforce this.
  // --------------------------------------------------------------------------
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_len <= WINDOW_LEN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      window_len <= cfg_data;
    end
  end

  assign eff_len = eff_len_f(window_len);
  assign lower_n = LEN_BITS'(({1'b0, eff_len} + (LEN_BITS+1)'(1)) >> 1);
  assign mid_idx = lower_n - LEN_BITS'(1);
  assign odd_len = eff_len[0];

  // --------------------------------------------------------------------------
  // Input side: write the ring, advance pointer and fill count.
  // Restart drops the old window before this sample lands.
  // --------------------------------------------------------------------------
  assign in_stall = (state != ST_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign wr_addr  = restart ? '0 : wr_ptr;

  always_comb begin
    if (restart) begin
      fill_new = LEN_BITS'(1);
    end else if (fill_count == LEN_BITS'(MAX_WINDOW)) begin
      fill_new = fill_count;
    end else begin
      fill_new = fill_count + LEN_BITS'(1);
    end
  end

  assign full = (fill_new >= eff_len);

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
      wr_ptr     <= '0;
    end else if (in_take) begin
      fill_count <= fill_new;
      wr_ptr     <= ptr_inc(wr_addr);
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      ring[wr_addr] <= sample;
    end
  end

  // --------------------------------------------------------------------------
  // Gather: read the last L samples newest first, one per cycle, and insert
  // each into the sort chain the cycle after its read.
  // --------------------------------------------------------------------------
  assign rd_en = (state == ST_GATHER) && (rd_cnt != eff_len);

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= ring[rd_ptr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ins_valid <= 1'b0;
    end else begin
      ins_valid <= rd_en;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      rd_ptr <= wr_addr;
      rd_cnt <= '0;
    end else if (rd_en) begin
      rd_ptr <= ptr_dec(rd_ptr);
      rd_cnt <= rd_cnt + LEN_BITS'(1);
    end
  end

  always_comb begin
    ctrl.clear  = in_take && full;
    ctrl.insert = ins_valid;
    ctrl.shift  = (state == ST_DRAIN);
    ctrl.data   = rd_data;
  end

  swmc_chain u_chain (
    .clk  (clk),
    .rst  (rst),
    .ctrl (ctrl),
    .head (head)
  );

  // --------------------------------------------------------------------------
  // Drain: pop sorted values off the head. Subtract the lower half, add the
  // upper half; for odd L the median itself nets to zero.
  // --------------------------------------------------------------------------
  assign head_ext = {{(COST_BITS-SAMPLE_BITS){head[SAMPLE_BITS-1]}}, head};

  always_ff @(posedge clk) begin
    if (state == ST_GATHER) begin
      drn_cnt <= '0;
      acc     <= '0;
    end else if (state == ST_DRAIN) begin
      drn_cnt <= drn_cnt + LEN_BITS'(1);
      if (drn_cnt < mid_idx) begin
        acc <= acc - head_ext;
      end else if (drn_cnt == mid_idx) begin
        med <= head;
        if (!odd_len) begin
          acc <= acc - head_ext;
        end
      end else begin
        acc <= acc + head_ext;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output register: load when empty or being taken this cycle.
  // --------------------------------------------------------------------------
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == ST_DONE) && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_DONE) && out_free) begin
      cost   <= COST_BITS'(acc);
      median <= med;
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_take && full) begin
          state_next = ST_GATHER;
        end
      end
      ST_GATHER: begin
        if ((rd_cnt == eff_len) && !ins_valid) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (drn_cnt == eff_len - LEN_BITS'(1)) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
